FILE: src/smac_pkg.sv
// shared types and operation codes for the simd multiply-accumulate unit
package smac_pkg;

  typedef enum logic [3:0] {
    FUNC_MADD    = 4'd0,
    FUNC_MADDU   = 4'd1,
    FUNC_PHMADH  = 4'd2,
    FUNC_PHMSBH  = 4'd3,
    FUNC_PMADDH  = 4'd4,
    FUNC_PMADDUW = 4'd5,
    FUNC_PMADDW  = 4'd6,
    FUNC_PMSUBH  = 4'd7,
    FUNC_PMSUBW  = 4'd8
  } func_e;

  localparam int unsigned NumHalf = 8;
  localparam int unsigned NumWord = 2;

  typedef struct packed {
    logic [NumHalf-1:0][31:0] hp;
    logic [NumWord-1:0][63:0] wp;
  } prod_t;

endpackage

FILE: src/smac_hmul.sv
// signed 16x16 halfword multiplier lane
module smac_hmul (
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [31:0] p_o
);
  logic signed [31:0] prod;

  assign prod = $signed(a_i) * $signed(b_i);
  assign p_o  = prod;
endmodule

FILE: src/smac_wmul.sv
// 32x32 word multiplier lane, signed or unsigned
module smac_wmul (
  input  logic        is_signed_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic signed [32:0] a_ext;
  logic signed [32:0] b_ext;
  logic signed [65:0] prod;

  assign a_ext = $signed({is_signed_i & a_i[31], a_i});
  assign b_ext = $signed({is_signed_i & b_i[31], b_i});
  assign prod  = a_ext * b_ext;
  assign p_o   = prod[63:0];
endmodule

FILE: src/smac_merge.sv
// merge stage: hi/lo accumulators and destination assembly from lane products
module smac_merge (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  smac_pkg::func_e func_i,
  input  smac_pkg::prod_t prod_i,
  output logic [63:0]   dest_lower_o,
  output logic [63:0]   dest_upper_o,
  output logic          dest_upper_valid_o
);
  import smac_pkg::*;

  logic [3:0][31:0] lo_q, lo_d;
  logic [3:0][31:0] hi_q, hi_d;
  logic [1:0][63:0] rw;
  logic [3:0][31:0] hv;
  logic [7:0][31:0] lv;
  logic [3:0][31:0] dw;
  logic             sub_w, sub_ph, sub_hh;

  assign sub_w  = (func_i == FUNC_PMSUBW);
  assign sub_hh = (func_i == FUNC_PHMSBH);
  assign sub_ph = (func_i == FUNC_PMSUBH);

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      rw[e] = sub_w ? ({hi_q[2*e], lo_q[2*e]} - prod_i.wp[e])
                    : ({hi_q[2*e], lo_q[2*e]} + prod_i.wp[e]);
    end
    for (int k = 0; k < 4; k++) begin
      hv[k] = sub_hh ? (prod_i.hp[2*k+1] - prod_i.hp[2*k])
                     : (prod_i.hp[2*k+1] + prod_i.hp[2*k]);
    end
    for (int k = 0; k < 8; k++) begin
      if ((k & 2) != 0) begin
        lv[k] = sub_ph ? (hi_q[(k & 1) | ((k >> 1) & 2)] - prod_i.hp[k])
                       : (hi_q[(k & 1) | ((k >> 1) & 2)] + prod_i.hp[k]);
      end else begin
        lv[k] = sub_ph ? (lo_q[(k & 1) | ((k >> 1) & 2)] - prod_i.hp[k])
                       : (lo_q[(k & 1) | ((k >> 1) & 2)] + prod_i.hp[k]);
      end
    end
  end

  always_comb begin
    lo_d               = lo_q;
    hi_d               = hi_q;
    dw                 = '0;
    dest_upper_valid_o = 1'b0;
    case (func_i)
      FUNC_MADD, FUNC_MADDU: begin
        lo_d[0] = rw[0][31:0];
        lo_d[1] = {32{rw[0][31]}};
        hi_d[0] = rw[0][63:32];
        hi_d[1] = {32{rw[0][63]}};
        dw[0]   = rw[0][31:0];
        dw[1]   = {32{rw[0][31]}};
      end
      FUNC_PMADDW, FUNC_PMADDUW, FUNC_PMSUBW: begin
        for (int e = 0; e < 2; e++) begin
          lo_d[2*e]   = rw[e][31:0];
          lo_d[2*e+1] = {32{rw[e][31]}};
          hi_d[2*e]   = rw[e][63:32];
          hi_d[2*e+1] = {32{rw[e][63]}};
          dw[2*e]     = rw[e][31:0];
          dw[2*e+1]   = rw[e][63:32];
        end
        dest_upper_valid_o = 1'b1;
      end
      FUNC_PHMADH, FUNC_PHMSBH: begin
        lo_d[0] = hv[0];
        lo_d[2] = hv[2];
        hi_d[0] = hv[1];
        hi_d[2] = hv[3];
        dw      = hv;
        dest_upper_valid_o = 1'b1;
      end
      FUNC_PMADDH, FUNC_PMSUBH: begin
        lo_d = {lv[5], lv[4], lv[1], lv[0]};
        hi_d = {lv[7], lv[6], lv[3], lv[2]};
        dw   = {lv[6], lv[4], lv[2], lv[0]};
        dest_upper_valid_o = 1'b1;
      end
      default: begin
        dw = '0;
      end
    endcase
  end

  assign dest_lower_o = {dw[1], dw[0]};
  assign dest_upper_o = {dw[3], dw[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (en_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end
endmodule

FILE: src/simd_multiply_accumulate_unit_top.sv
// top level of the simd multiply-accumulate unit
// products are registered in the input stage, then accumulated in the merge stage
// throughput: one item per cycle when not stalled; the merge-stage add closes the loop
// the input stage holds while the output register is stalled, and refills as it drains
// reset: asynchronous active low, clears hi/lo accumulators and pipeline valid flags
module simd_multiply_accumulate_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  func_i,
  input  logic [63:0] src_a_lower_i,
  input  logic [63:0] src_a_upper_i,
  input  logic [63:0] src_b_lower_i,
  input  logic [63:0] src_b_upper_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] dest_lower_o,
  output logic [63:0] dest_upper_o,
  output logic        dest_upper_valid_o
);
  import smac_pkg::*;

  logic [127:0] a_all, b_all;
  logic         w_signed;
  prod_t        prod_d, prod_q;
  func_e        func_q;
  logic         s1_valid_q;
  logic         s1_en, s2_en;
  logic [63:0]  m_lower, m_upper;
  logic         m_upv;
  logic [63:0]  dest_lower_q, dest_upper_q;
  logic         dest_upv_q;
  logic         out_valid_q;

  assign a_all    = {src_a_upper_i, src_a_lower_i};
  assign b_all    = {src_b_upper_i, src_b_lower_i};
  assign w_signed = (func_i != FUNC_MADDU) && (func_i != FUNC_PMADDUW);

  for (genvar i = 0; i < NumHalf; i++) begin : g_hlane
    smac_hmul u_hmul (
      .a_i (a_all[16*i +: 16]),
      .b_i (b_all[16*i +: 16]),
      .p_o (prod_d.hp[i])
    );
  end

  for (genvar e = 0; e < NumWord; e++) begin : g_wlane
    smac_wmul u_wmul (
      .is_signed_i (w_signed),
      .a_i         (a_all[64*e +: 32]),
      .b_i         (b_all[64*e +: 32]),
      .p_o         (prod_d.wp[e])
    );
  end

  assign s2_en      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_en;
  assign s1_en      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= 1'b1;
    end else if (s2_en) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      prod_q <= prod_d;
      func_q <= func_e'(func_i);
    end
  end

  smac_merge u_merge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (s2_en),
    .func_i             (func_q),
    .prod_i             (prod_q),
    .dest_lower_o       (m_lower),
    .dest_upper_o       (m_upper),
    .dest_upper_valid_o (m_upv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      dest_lower_q <= m_lower;
      dest_upper_q <= m_upper;
      dest_upv_q   <= m_upv;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign dest_lower_o       = dest_lower_q;
  assign dest_upper_o       = dest_upper_q;
  assign dest_upper_valid_o = dest_upv_q;

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_en |=> s1_valid_q)
    else $error("stage one item dropped while stalled");

  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input not ready without a full stalled pipeline");

  a_s2_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_en |=> out_valid_o)
    else $error("merged result not presented");

  a_upper_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dest_upper_valid_o |-> dest_upper_o == 64'd0)
    else $error("upper half nonzero while not written");
endmodule

FILE: test/simd_multiply_accumulate_unit_checker.sv
// checker for the simd multiply-accumulate unit: hi/lo accumulator prediction and result compare
module simd_multiply_accumulate_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [3:0]  func_i,
  input  logic [63:0] src_a_lower_i,
  input  logic [63:0] src_a_upper_i,
  input  logic [63:0] src_b_lower_i,
  input  logic [63:0] src_b_upper_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] dest_lower_i,
  input  logic [63:0] dest_upper_i,
  input  logic        dest_upper_valid_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import smac_pkg::*;

  localparam int MaxPrinted = 40;

  typedef struct packed {
    logic [63:0] lower;
    logic [63:0] upper;
    logic        upper_valid;
  } dest_t;

  logic [63:0] lo_acc [2];
  logic [63:0] hi_acc [2];
  dest_t       dest_q [$];
  int          fails;
  int          checked;

  initial begin
    fails   = 0;
    checked = 0;
  end

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    fails++;
    if (fails <= MaxPrinted) begin
      $display("%0t ns: %s mismatch at result %0d: got %h, expected %h",
               $time, field, checked, got, want);
    end
  endtask

  function automatic logic [63:0] sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] half_prod(logic [127:0] a, logic [127:0] b, int i);
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] sx;
    logic [31:0] sy;
    x  = a[16*i +: 16];
    y  = b[16*i +: 16];
    sx = {{16{x[15]}}, x};
    sy = {{16{y[15]}}, y};
    return sx * sy;
  endfunction

  // one 64-bit hi/lo lane: full-width product added to or taken from {hi word, lo word}
  function automatic logic [63:0] word_mac(logic [127:0] a, logic [127:0] b, int e,
                                           bit sgn, bit sub);
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] r;
    x   = a[64*e +: 32];
    y   = b[64*e +: 32];
    acc = {hi_acc[e][31:0], lo_acc[e][31:0]};
    if (sgn) begin
      p = {{32{x[31]}}, x} * {{32{y[31]}}, y};
    end else begin
      p = {32'd0, x} * {32'd0, y};
    end
    r = sub ? acc - p : acc + p;
    lo_acc[e] = sext32(r[31:0]);
    hi_acc[e] = sext32(r[63:32]);
    return r;
  endfunction

  function automatic dest_t mac_step(logic [3:0] f, logic [127:0] a, logic [127:0] b);
    logic [127:0] d;
    logic [63:0]  r;
    logic [31:0]  v [8];
    logic [31:0]  c;
    logic [31:0]  p0;
    logic [31:0]  p1;
    dest_t        res;
    int           w;
    d = '0;
    res.upper_valid = 1'b1;
    case (f)
      FUNC_MADD, FUNC_MADDU: begin
        r = word_mac(a, b, 0, f == FUNC_MADD, 1'b0);
        d[63:0] = sext32(r[31:0]);
        res.upper_valid = 1'b0;
      end
      FUNC_PMADDUW, FUNC_PMADDW, FUNC_PMSUBW: begin
        d[63:0]   = word_mac(a, b, 0, f != FUNC_PMADDUW, f == FUNC_PMSUBW);
        d[127:64] = word_mac(a, b, 1, f != FUNC_PMADDUW, f == FUNC_PMSUBW);
      end
      FUNC_PHMADH, FUNC_PHMSBH: begin
        for (int k = 0; k < 4; k++) begin
          p1 = half_prod(a, b, 2*k + 1);
          p0 = half_prod(a, b, 2*k);
          v[k] = (f == FUNC_PHMADH) ? p1 + p0 : p1 - p0;
          d[32*k +: 32] = v[k];
        end
        lo_acc[0][31:0] = v[0];
        lo_acc[1][31:0] = v[2];
        hi_acc[0][31:0] = v[1];
        hi_acc[1][31:0] = v[3];
      end
      FUNC_PMADDH, FUNC_PMSUBH: begin
        // lanes map to lo0 lo1 hi0 hi1 lo2 lo3 hi2 hi3
        for (int k = 0; k < 8; k++) begin
          w = (k & 1) | ((k >> 1) & 2);
          c = ((k & 2) != 0) ? hi_acc[w >> 1][32*(w & 1) +: 32]
                             : lo_acc[w >> 1][32*(w & 1) +: 32];
          p0 = half_prod(a, b, k);
          v[k] = (f == FUNC_PMADDH) ? c + p0 : c - p0;
        end
        for (int k = 0; k < 8; k++) begin
          w = (k & 1) | ((k >> 1) & 2);
          if ((k & 2) != 0) begin
            hi_acc[w >> 1][32*(w & 1) +: 32] = v[k];
          end else begin
            lo_acc[w >> 1][32*(w & 1) +: 32] = v[k];
          end
        end
        for (int k = 0; k < 4; k++) begin
          d[32*k +: 32] = v[2*k];
        end
      end
      default: begin
        res.upper_valid = 1'b0;
      end
    endcase
    res.lower = d[63:0];
    res.upper = res.upper_valid ? d[127:64] : 64'd0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dest_t want;
    if (!rst_ni) begin
      lo_acc[0] = '0;
      lo_acc[1] = '0;
      hi_acc[0] = '0;
      hi_acc[1] = '0;
      dest_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (dest_q.size() == 0) begin
          report_mismatch("unexpected transfer, lower", dest_lower_i, 64'd0);
        end else begin
          want = dest_q.pop_front();
          if (dest_lower_i !== want.lower) begin
            report_mismatch("dest_lower", dest_lower_i, want.lower);
          end
          if (dest_upper_i !== want.upper) begin
            report_mismatch("dest_upper", dest_upper_i, want.upper);
          end
          if (dest_upper_valid_i !== want.upper_valid) begin
            report_mismatch("dest_upper_valid", 64'(dest_upper_valid_i),
                            64'(want.upper_valid));
          end
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        dest_q.push_back(mac_step(func_i, {src_a_upper_i, src_a_lower_i},
                                  {src_b_upper_i, src_b_lower_i}));
      end
    end
    fail_count_o <= fails;
    pending_o    <= dest_q.size();
    checked_o    <= checked;
  end

endmodule

FILE: test/simd_multiply_accumulate_unit_top_tb.sv
// testbench top for the simd multiply-accumulate unit: stimulus, flow control and verdict
module simd_multiply_accumulate_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smac_pkg::*;

  localparam logic [3:0] FuncUnusedLo = 4'd9;
  localparam logic [3:0] FuncUnusedHi = 4'd15;
  localparam int NumRandom  = 1000;
  localparam int HoldAfter  = 400;
  localparam int HoldCycles = 120;
  localparam int DrainWait  = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  func = FUNC_MADD;
  logic [63:0] src_a_lower = '0;
  logic [63:0] src_a_upper = '0;
  logic [63:0] src_b_lower = '0;
  logic [63:0] src_b_upper = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] dest_lower;
  logic [63:0] dest_upper;
  logic        dest_upper_valid;
  int          fail_count;
  int          pending;
  int          checked;
  int          n_sent = 0;
  int          n_unused = 0;
  bit          idle_on = 1'b1;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  simd_multiply_accumulate_unit_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .func_i             (func),
    .src_a_lower_i      (src_a_lower),
    .src_a_upper_i      (src_a_upper),
    .src_b_lower_i      (src_b_lower),
    .src_b_upper_i      (src_b_upper),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .dest_lower_o       (dest_lower),
    .dest_upper_o       (dest_upper),
    .dest_upper_valid_o (dest_upper_valid)
  );

  simd_multiply_accumulate_unit_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .func_i             (func),
    .src_a_lower_i      (src_a_lower),
    .src_a_upper_i      (src_a_upper),
    .src_b_lower_i      (src_b_lower),
    .src_b_upper_i      (src_b_upper),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .dest_lower_i       (dest_lower),
    .dest_upper_i       (dest_upper),
    .dest_upper_valid_i (dest_upper_valid),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7fff;
      3: return 16'h8000;
      4: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    int          m;
    m = $urandom_range(0, 9);
    if (m < 5) begin
      v = {$urandom, $urandom};
    end else if (m < 8) begin
      for (int i = 0; i < 4; i++) begin
        v[16*i +: 16] = pick_half();
      end
    end else begin
      v = {32'($urandom_range(0, 63)) - 32'd32, 32'($urandom_range(0, 63)) - 32'd32};
    end
    return v;
  endfunction

  task automatic send_item(logic [3:0] f, logic [127:0] a, logic [127:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    func        <= f;
    src_a_lower <= a[63:0];
    src_a_upper <= a[127:64];
    src_b_lower <= b[63:0];
    src_b_upper <= b[127:64];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    n_sent++;
    if (f > FUNC_PMSUBW) begin
      n_unused++;
    end
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin : sink
    int  burst;
    int  gap;
    bit  held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && n_sent >= HoldAfter) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      burst = $urandom_range(1, 24);
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : stim
    logic [3:0] f;
    int         n;
    int         run;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of word and halfword products, carries into hi, every operation
    send_item(FUNC_MADD, '0, '0);
    send_item(FUNC_MADD, {96'd0, 32'hffff_ffff}, {96'd0, 32'hffff_ffff});
    send_item(FUNC_MADD, {4{32'h8000_0000}}, {4{32'h8000_0000}});
    send_item(FUNC_MADD, {4{32'h7fff_ffff}}, {4{32'h8000_0000}});
    send_item(FUNC_MADDU, '1, '1);
    send_item(FUNC_MADDU, '1, '1);
    send_item(FUNC_PMADDW, '1, '1);
    send_item(FUNC_PMADDW, {4{32'h8000_0000}}, {4{32'h8000_0000}});
    send_item(FUNC_PMSUBW, {4{32'h7fff_ffff}}, {4{32'h8000_0000}});
    send_item(FUNC_PMSUBW, '1, {4{32'h7fff_ffff}});
    send_item(FUNC_PMADDUW, '1, '1);
    send_item(FUNC_PMADDUW, '1, '1);
    send_item(FUNC_PHMADH, {8{16'h8000}}, {8{16'h8000}});
    send_item(FUNC_PHMADH, {8{16'h7fff}}, {8{16'h8000}});
    send_item(FUNC_PHMSBH, {4{16'h8000, 16'h7fff}}, {4{16'h8000, 16'h7fff}});
    send_item(FUNC_PMADDH, {8{16'h8000}}, {8{16'h8000}});
    send_item(FUNC_PMADDH, {8{16'h8000}}, {8{16'h8000}});
    send_item(FUNC_PMSUBH, {8{16'h7fff}}, {8{16'h8000}});
    send_item(FUNC_PMSUBH, '1, '1);
    send_item(FuncUnusedLo, '1, '1);
    send_item(FuncUnusedHi, '1, '1);
    send_item(FUNC_MADD, '0, '0);
    send_item(FUNC_PMADDW, '0, '0);

    // runs of one operation so the accumulators build up
    n = 0;
    while (n < NumRandom) begin
      idle_on = ((n / 100) % 4) != 1;
      if ($urandom_range(0, 15) == 0) begin
        f = 4'($urandom_range(FuncUnusedLo, FuncUnusedHi));
      end else begin
        f = 4'($urandom_range(FUNC_MADD, FUNC_PMSUBW));
      end
      run = $urandom_range(1, 8);
      for (int j = 0; j < run && n < NumRandom; j++) begin
        send_item(f, {pick_operand(), pick_operand()}, {pick_operand(), pick_operand()});
        n++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (checked == n_sent);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d input transfers (%0d with unused codes) and %0d compared results,",
             n_sent, n_unused, checked);
    $display("with random stalls on both sides and one long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("simd_multiply_accumulate_unit_top_tb passed");
    end else begin
      $display("simd_multiply_accumulate_unit_top_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", n_sent - checked);
    $display("simd_multiply_accumulate_unit_top_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/smac_pkg.sv
src/smac_hmul.sv
src/smac_wmul.sv
src/smac_merge.sv
src/simd_multiply_accumulate_unit_top.sv
test/simd_multiply_accumulate_unit_checker.sv
test/simd_multiply_accumulate_unit_top_tb.sv
